/* design/bounded_frame_fifo_with_stats_macros.svh */
// assertion macros of the frame queue datapath
`ifndef BOUNDED_FRAME_FIFO_WITH_STATS_MACROS_SVH
`define BOUNDED_FRAME_FIFO_WITH_STATS_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define BFFS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bffs assertion failed");
// next-cycle implication, checked out of reset
`define BFFS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bffs assertion failed");
`else
`define BFFS_ASSERT_IMP(lbl, ante, cons)
`define BFFS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* design/bffs_pkg.sv */
// shared types and codes of the bounded frame queue
package bffs_pkg;

	// action codes of an input item
	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_GET   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_NOP   = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_GET  = 2'd1;
	localparam logic [1:0] KIND_RET  = 2'd2;

	// limit register reset value
	localparam logic [5:0] MAX_LENGTH_RESET = 6'd32;

	// commands from controller to datapath
	typedef struct packed {
		logic       put_store;
		logic       put_drop;
		logic       pop;
		logic       ptr_reset;
		logic       load_imm;
		logic       load_mem;
		logic       drain;
		logic [1:0] kind;
	} bffs_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic out_valid;
	} bffs_stat_t;

endpackage

/* design/bffs_ctrl.sv */
// controller state machine of the bounded frame queue
module bffs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic [1:0]          s_tuser,
	output logic                s_tready,
	input  logic                m_tready,
	input  bffs_pkg::bffs_stat_t stat,
	output bffs_pkg::bffs_cmd_t  cmd
);
	import bffs_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EMIT = 1'b1;

	logic state_q;
	logic state_d;
	logic drain_q;
	logic drain_d;
	logic out_free;
	logic take;

	// output register can take a new item this cycle
	assign out_free = !stat.out_valid || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign take     = s_tvalid && s_tready;

	// command decode
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		drain_d = drain_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (s_tuser)
						ACT_PUT: begin
							cmd.load_imm = 1'b1;
							if (stat.full) begin
								cmd.put_drop = 1'b1;
								cmd.kind     = KIND_RET;
							end else begin
								cmd.put_store = 1'b1;
								cmd.kind      = KIND_NONE;
							end
						end
						ACT_GET: begin
							if (stat.empty) begin
								cmd.load_imm = 1'b1;
								cmd.kind     = KIND_NONE;
							end else begin
								cmd.pop = 1'b1;
								drain_d = 1'b0;
								state_d = S_EMIT;
							end
						end
						ACT_CLEAR: begin
							if (stat.empty) begin
								cmd.load_imm  = 1'b1;
								cmd.ptr_reset = 1'b1;
								cmd.kind      = KIND_NONE;
							end else begin
								cmd.pop = 1'b1;
								drain_d = 1'b1;
								state_d = S_EMIT;
							end
						end
						default: begin
							cmd.load_imm = 1'b1;
							cmd.kind     = KIND_NONE;
						end
					endcase
				end
			end
			default: begin
				// hand out the popped handle, keep draining on clear
				if (out_free) begin
					cmd.load_mem = 1'b1;
					cmd.drain    = drain_q;
					cmd.kind     = drain_q ? KIND_RET : KIND_GET;
					if (drain_q && !stat.empty) begin
						cmd.pop = 1'b1;
					end else begin
						cmd.ptr_reset = drain_q;
						state_d       = S_IDLE;
					end
				end
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			drain_q <= drain_d;
		end
	end

endmodule

/* design/bffs_dpath.sv */
// datapath of the bounded frame queue: slot memory, pointers, statistics, output register
`include "bounded_frame_fifo_with_stats_macros.svh"
module bffs_dpath #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bffs_pkg::bffs_cmd_t  cmd,
	output bffs_pkg::bffs_stat_t stat,
	input  logic [15:0]          in_handle,
	input  logic [31:0]          in_time,
	input  logic                 cfg_valid,
	input  logic [5:0]           cfg_data,
	input  logic                 m_tready,
	output logic                 out_valid,
	output logic [1:0]           out_kind,
	output logic                 out_last,
	output logic [15:0]          out_handle,
	output logic [5:0]           out_length,
	output logic [31:0]          out_total,
	output logic [5:0]           out_peak,
	output logic [31:0]          out_dropped,
	output logic [31:0]          out_low,
	output logic [31:0]          out_high
);
	import bffs_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = LEN_W + 6;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(QUEUE_DEPTH);

	logic [15:0]      mem [QUEUE_DEPTH];
	logic [15:0]      rd_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] peak_q;
	logic [31:0]      acc_q;
	logic [31:0]      drop_q;
	logic [31:0]      low_q;
	logic [31:0]      high_q;
	logic [31:0]      prev_q;
	logic [5:0]       max_len_q;

	logic [LEN_W-1:0] len_d;
	logic [LEN_W-1:0] peak_d;
	logic [31:0]      acc_d;
	logic [31:0]      drop_d;
	logic [31:0]      low_d;
	logic [31:0]      high_d;
	logic [31:0]      prev_d;
	logic [31:0]      gap;
	logic [CMP_W-1:0] lim_ext;
	logic [CMP_W-1:0] limit;
	logic [CMP_W-1:0] len_ext;
	logic [CMP_W-1:0] len_d_ext;
	logic [CMP_W-1:0] peak_d_ext;

	// effective limit and status
	assign lim_ext    = {{LEN_W{1'b0}}, max_len_q};
	assign limit      = (lim_ext > DEPTH_C) ? DEPTH_C : lim_ext;
	assign len_ext    = {6'b0, len_q};
	assign stat.empty = (len_q == '0);
	assign stat.full  = (len_ext >= limit);
	assign stat.out_valid = out_valid;

	// next statistics
	assign gap = in_time - prev_q;
	always_comb begin
		len_d  = len_q;
		peak_d = peak_q;
		acc_d  = acc_q;
		drop_d = drop_q;
		low_d  = low_q;
		high_d = high_q;
		prev_d = prev_q;
		if (cmd.put_store) begin
			len_d = len_q + LEN_W'(1);
			acc_d = acc_q + 32'd1;
			if (len_d > peak_q) begin
				peak_d = len_d;
			end
			if (prev_q != 32'd0) begin
				if (gap < low_q) begin
					low_d = gap;
				end
				if (gap > high_q) begin
					high_d = gap;
				end
			end
			prev_d = in_time;
		end
		if (cmd.put_drop) begin
			drop_d = drop_q + 32'd1;
		end
		if (cmd.pop) begin
			len_d = len_q - LEN_W'(1);
		end
	end

	assign len_d_ext  = {6'b0, len_d};
	assign peak_d_ext = {6'b0, peak_d};

	// control registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			len_q     <= '0;
			peak_q    <= '0;
			acc_q     <= '0;
			drop_q    <= '0;
			low_q     <= '1;
			high_q    <= '0;
			prev_q    <= '0;
			max_len_q <= MAX_LENGTH_RESET;
		end else begin
			len_q  <= len_d;
			peak_q <= peak_d;
			acc_q  <= acc_d;
			drop_q <= drop_d;
			low_q  <= low_d;
			high_q <= high_d;
			prev_q <= prev_d;
			if (cfg_valid) begin
				max_len_q <= cfg_data;
			end
			priority if (cmd.ptr_reset) begin
				head_q <= '0;
			end else if (cmd.pop) begin
				head_q <= (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
			end
			priority if (cmd.ptr_reset) begin
				tail_q <= '0;
			end else if (cmd.put_store) begin
				tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
			end
		end
	end

	// slot memory with registered read
	always_ff @(posedge clk) begin
		if (cmd.put_store) begin
			mem[tail_q] <= in_handle;
		end
		if (cmd.pop) begin
			rd_q <= mem[head_q];
		end
	end

	// output item valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_imm || cmd.load_mem) begin
			out_valid <= 1'b1;
		end else if (m_tready) begin
			out_valid <= 1'b0;
		end
	end

	// output item payload
	always_ff @(posedge clk) begin
		if (cmd.load_imm || cmd.load_mem) begin
			out_kind    <= cmd.kind;
			out_total   <= acc_d;
			out_peak    <= peak_d_ext[5:0];
			out_dropped <= drop_d;
			out_low     <= low_d;
			out_high    <= high_d;
			if (cmd.load_mem) begin
				out_handle <= rd_q;
				out_last   <= cmd.drain ? (len_q == '0) : 1'b1;
				out_length <= cmd.drain ? 6'd0 : len_ext[5:0];
			end else begin
				out_handle <= (cmd.kind == KIND_RET) ? in_handle : 16'd0;
				out_last   <= 1'b1;
				out_length <= len_d_ext[5:0];
			end
		end
	end

	`BFFS_ASSERT_IMP(a_len_bound, 1'b1, len_ext <= DEPTH_C)
	`BFFS_ASSERT_IMP(a_pop_nonempty, cmd.pop, len_q != '0)
	`BFFS_ASSERT_IMP(a_store_below_limit, cmd.put_store, !stat.full)
	`BFFS_ASSERT_NXT(a_load_valid, cmd.load_imm || cmd.load_mem, out_valid)

endmodule

/* design/bounded_frame_fifo_with_stats.sv */
// top level of the bounded frame queue with drop-tail and statistics
//
// channel  | direction | contents
// s_*      | in        | tuser action, tdata frame handle and arrival time
// m_*      | out       | tuser kind, tlast last, tdata handle and statistics
// cfg_*    | in        | max_length limit write, always ready
//
// put, drop, empty get, empty clear and no-op: the result is loaded into the
// output register at the accepting edge. get on a non-empty queue: the slot
// memory read is registered, then loaded into the output register when free.
// clear: one returned item per cycle from the registered memory read while the
// output register is free. s_tready is low while a get or clear is in work and
// whenever the output register holds an item that m_tready does not take.
// reset clears pointers, length and statistics; slot memory is not cleared.
module bounded_frame_fifo_with_stats #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [15:0] frame_handle, [47:16] arrive_time
	input  logic [47:0]  s_tdata,
	// [1:0] action
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] frame_handle_out, [21:16] length, [53:22] total_accepted,
	// [59:54] max_depth, [91:60] overflow_count, [123:92] min_interval,
	// [155:124] max_interval, [159:156] zero
	output logic [159:0] m_tdata,
	// [1:0] kind
	output logic [1:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [5:0]   cfg_data
);
	import bffs_pkg::*;

	bffs_cmd_t  cmd;
	bffs_stat_t stat;

	logic [15:0] out_handle;
	logic [5:0]  out_length;
	logic [31:0] out_total;
	logic [5:0]  out_peak;
	logic [31:0] out_dropped;
	logic [31:0] out_low;
	logic [31:0] out_high;

	assign cfg_ready = 1'b1;

	// controller
	bffs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	bffs_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_handle   (s_tdata[15:0]),
		.in_time     (s_tdata[47:16]),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.m_tready    (m_tready),
		.out_valid   (m_tvalid),
		.out_kind    (m_tuser),
		.out_last    (m_tlast),
		.out_handle  (out_handle),
		.out_length  (out_length),
		.out_total   (out_total),
		.out_peak    (out_peak),
		.out_dropped (out_dropped),
		.out_low     (out_low),
		.out_high    (out_high)
	);

	// pack the result item
	assign m_tdata = {4'b0, out_high, out_low, out_dropped, out_peak,
		out_total, out_length, out_handle};

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench of the bounded frame queue with drop-tail and statistics
module tb_top;
	import bffs_pkg::*;

	localparam int SLOTS      = 32;
	localparam int DIRECTED_N = 20;
	localparam int PHASES     = 8;

	// one result item as it leaves the block
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] handle;
		logic        last;
		logic [5:0]  length;
		logic [31:0] accepted;
		logic [5:0]  peak;
		logic [31:0] dropped;
		logic [31:0] gap_min;
		logic [31:0] gap_max;
	} frame_result_t;

	// one directed stimulus row, optionally with a typed-in expectation
	typedef struct packed {
		logic [1:0]    act;
		logic [15:0]   handle;
		logic [31:0]   arrive;
		logic          typed;
		frame_result_t want;
	} stim_row_t;

	logic         clk;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [47:0]  s_tdata   = '0;
	logic [1:0]   s_tuser   = ACT_NOP;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [159:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [5:0]   cfg_data  = '0;

	bounded_frame_fifo_with_stats #(.QUEUE_DEPTH(SLOTS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predictor state
	logic [15:0]   held_frames[$];
	logic [5:0]    limit_val    = MAX_LENGTH_RESET;
	logic [31:0]   acc_count    = '0;
	logic [5:0]    peak_len     = '0;
	logic [31:0]   drop_count   = '0;
	logic [31:0]   gap_low      = '1;
	logic [31:0]   gap_high     = '0;
	logic [31:0]   last_arrival = '0;
	frame_result_t step_outcomes[$];
	frame_result_t pending_outcomes[$];

	int            errors = 0;
	int            tx_pct = 0;
	int            rx_pct = 0;
	logic [31:0]   tick_now = 32'd1000;
	stim_row_t     directed_rows[DIRECTED_N];
	logic [5:0]    phase_limits[PHASES];

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5000000;
		$display("[bounded_frame_fifo_with_stats] ERROR");
		$finish;
	end

	// result with no frame, as left by an accepted put, empty get, empty clear or no-op
	function automatic frame_result_t quiet_result(logic [5:0] len, logic [31:0] acc,
			logic [5:0] pk, logic [31:0] drp, logic [31:0] lo, logic [31:0] hi);
		frame_result_t r;
		r = '{kind: KIND_NONE, handle: 16'h0, last: 1'b1, length: len, accepted: acc,
			peak: pk, dropped: drp, gap_min: lo, gap_max: hi};
		return r;
	endfunction

	// next frame result of the current step, statistics filled in later
	function automatic frame_result_t frame_item(logic [1:0] k, logic [15:0] h);
		frame_result_t r;
		r = '0;
		r.kind   = k;
		r.handle = h;
		return r;
	endfunction

	// queue behavior for one accepted item, results collected in step_outcomes
	task automatic queue_step_outcome(input logic [1:0] act, input logic [15:0] h,
			input logic [31:0] t);
		int          eff;
		logic [31:0] gap;
		eff = (limit_val > SLOTS) ? SLOTS : int'(limit_val);
		step_outcomes.delete();
		case (act)
			ACT_PUT: begin
				if (held_frames.size() >= eff) begin
					drop_count++;
					step_outcomes.push_back(frame_item(KIND_RET, h));
				end else begin
					held_frames.push_back(h);
					acc_count++;
					if (held_frames.size() > peak_len)
						peak_len = 6'(held_frames.size());
					// interval rule skipped while the previous arrival is zero
					if (last_arrival != 0) begin
						gap = t - last_arrival;
						if (gap < gap_low)
							gap_low = gap;
						if (gap > gap_high)
							gap_high = gap;
					end
					last_arrival = t;
					step_outcomes.push_back(frame_item(KIND_NONE, 16'h0));
				end
			end
			ACT_GET: begin
				if (held_frames.size() > 0)
					step_outcomes.push_back(frame_item(KIND_GET, held_frames.pop_front()));
				else
					step_outcomes.push_back(frame_item(KIND_NONE, 16'h0));
			end
			ACT_CLEAR: begin
				while (held_frames.size() > 0)
					step_outcomes.push_back(frame_item(KIND_RET, held_frames.pop_front()));
				if (step_outcomes.size() == 0)
					step_outcomes.push_back(frame_item(KIND_NONE, 16'h0));
			end
			default: step_outcomes.push_back(frame_item(KIND_NONE, 16'h0));
		endcase
		// every result of a step carries the after-step statistics
		foreach (step_outcomes[k]) begin
			step_outcomes[k].last     = (k == step_outcomes.size() - 1);
			step_outcomes[k].length   = 6'(held_frames.size());
			step_outcomes[k].accepted = acc_count;
			step_outcomes[k].peak     = peak_len;
			step_outcomes[k].dropped  = drop_count;
			step_outcomes[k].gap_min  = gap_low;
			step_outcomes[k].gap_max  = gap_high;
		end
	endtask

	// present one item at a falling edge, hold it until accepted; returns at a falling edge
	task automatic send_item(input logic [1:0] act, input logic [15:0] h, input logic [31:0] t,
			input logic typed, input frame_result_t want);
		while ($urandom_range(99) < tx_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {t, h};
		do
			@(posedge clk);
		while (!s_tready);
		queue_step_outcome(act, h, t);
		if (typed)
			pending_outcomes.push_back(want);
		else
			foreach (step_outcomes[k])
				pending_outcomes.push_back(step_outcomes[k]);
		@(negedge clk);
	endtask

	// stop sending and wait until every expected result has come
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// limit register write, only while the block is idle
	task automatic write_limit(input logic [5:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		limit_val = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// arrival time: mostly rising, sometimes zero, backwards or anywhere
	function automatic logic [31:0] next_arrival();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return 32'h0;
		if (r == 1)
			tick_now = $urandom;
		else if (r == 2)
			tick_now = tick_now - $urandom_range(1, 500);
		else
			tick_now = tick_now + $urandom_range(1, 200);
		return tick_now;
	endfunction

	// receiver stalls
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= rx_pct);

	// result checking against the oldest expectation
	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		frame_result_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outcomes.size() == 0) begin
				errors++;
				$display("%0t: unexpected result expected none actual kind %0d handle %h",
					$time, m_tuser, m_tdata[15:0]);
			end else begin
				w = pending_outcomes.pop_front();
				compare_field("kind", 32'(w.kind), 32'(m_tuser));
				compare_field("frame_handle_out", 32'(w.handle), 32'(m_tdata[15:0]));
				compare_field("last", 32'(w.last), 32'(m_tlast));
				compare_field("length", 32'(w.length), 32'(m_tdata[21:16]));
				compare_field("total_accepted", w.accepted, m_tdata[53:22]);
				compare_field("max_depth", 32'(w.peak), 32'(m_tdata[59:54]));
				compare_field("overflow_count", w.dropped, m_tdata[91:60]);
				compare_field("min_interval", w.gap_min, m_tdata[123:92]);
				compare_field("max_interval", w.gap_max, m_tdata[155:124]);
			end
		end
	end

	// stimulus
	initial begin
		int            counted;
		int            burst;
		int            gets;
		int            r;
		logic [1:0]    act;
		logic          paused;
		frame_result_t none_r;
		none_r = '0;
		paused = 1'b0;

		// directed rows: empty operations after reset, extremes, wrapping intervals, clears
		directed_rows[0]  = '{ACT_GET,   16'h0000, 32'h0,
			1'b1, quiet_result(6'd0, 32'd0, 6'd0, 32'd0, 32'hFFFF_FFFF, 32'd0)};
		directed_rows[1]  = '{ACT_CLEAR, 16'h0000, 32'h0,
			1'b1, quiet_result(6'd0, 32'd0, 6'd0, 32'd0, 32'hFFFF_FFFF, 32'd0)};
		directed_rows[2]  = '{ACT_NOP,   16'hFFFF, 32'hFFFF_FFFF,
			1'b1, quiet_result(6'd0, 32'd0, 6'd0, 32'd0, 32'hFFFF_FFFF, 32'd0)};
		directed_rows[3]  = '{ACT_PUT,   16'hFFFF, 32'h0,
			1'b1, quiet_result(6'd1, 32'd1, 6'd1, 32'd0, 32'hFFFF_FFFF, 32'd0)};
		directed_rows[4]  = '{ACT_PUT,   16'h0000, 32'd100,
			1'b1, quiet_result(6'd2, 32'd2, 6'd2, 32'd0, 32'hFFFF_FFFF, 32'd0)};
		directed_rows[5]  = '{ACT_PUT,   16'h1234, 32'd50,         1'b0, none_r};
		directed_rows[6]  = '{ACT_PUT,   16'h8000, 32'hFFFF_FFFF,  1'b0, none_r};
		directed_rows[7]  = '{ACT_PUT,   16'h0001, 32'd3,          1'b0, none_r};
		directed_rows[8]  = '{ACT_GET,   16'h0000, 32'h0,          1'b0, none_r};
		directed_rows[9]  = '{ACT_GET,   16'hFFFF, 32'hFFFF_FFFF,  1'b0, none_r};
		directed_rows[10] = '{ACT_NOP,   16'h0000, 32'h0,          1'b0, none_r};
		directed_rows[11] = '{ACT_CLEAR, 16'h5A5A, 32'h1234_5678,  1'b0, none_r};
		directed_rows[12] = '{ACT_GET,   16'h0000, 32'h0,          1'b0, none_r};
		directed_rows[13] = '{ACT_PUT,   16'hAAAA, 32'h0,          1'b0, none_r};
		directed_rows[14] = '{ACT_PUT,   16'h5555, 32'd7,          1'b0, none_r};
		directed_rows[15] = '{ACT_PUT,   16'h00FF, 32'd9,          1'b0, none_r};
		directed_rows[16] = '{ACT_CLEAR, 16'h0000, 32'h0,          1'b0, none_r};
		directed_rows[17] = '{ACT_PUT,   16'hFF00, 32'hFFFF_FFFF,  1'b0, none_r};
		directed_rows[18] = '{ACT_PUT,   16'h0F0F, 32'h8000_0000,  1'b0, none_r};
		directed_rows[19] = '{ACT_GET,   16'h0000, 32'h0,          1'b0, none_r};

		// limits per phase, including zero, one, the depth and above it
		phase_limits = '{6'd63, 6'd1, 6'd0, 6'd2, 6'd32, 6'd33, 6'd7, 6'd32};

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].act, directed_rows[i].handle, directed_rows[i].arrive,
				directed_rows[i].typed, directed_rows[i].want);

		// random phases, each with its own limit and idle pattern
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_limit(phase_limits[p]);
			case (p % 4)
				0: begin tx_pct = 0;  rx_pct = 0;  end
				1: begin tx_pct = 63; rx_pct = 0;  end
				2: begin tx_pct = 0;  rx_pct = 63; end
				default: begin tx_pct = 21; rx_pct = 21; end
			endcase
			counted = 0;
			while (counted < 20) begin
				// once, the sender holds off until the queue output has caught up
				if (p == 1 && !paused && counted >= 10) begin
					wait_drained();
					paused = 1'b1;
				end
				if ($urandom_range(3) == 0) begin
					// fill past the limit, then take some back
					burst = ((phase_limits[p] > SLOTS) ? SLOTS : phase_limits[p]) + 2;
					for (int b = 0; b < burst; b++)
						send_item(ACT_PUT, 16'($urandom), next_arrival(), 1'b0, none_r);
					gets = $urandom_range(1, 4);
					for (int b = 0; b < gets; b++)
						send_item(ACT_GET, 16'($urandom), $urandom, 1'b0, none_r);
					counted += burst + gets;
				end else begin
					r = $urandom_range(99);
					if (r < 45)
						act = ACT_PUT;
					else if (r < 80)
						act = ACT_GET;
					else if (r < 90)
						act = ACT_CLEAR;
					else
						act = ACT_NOP;
					send_item(act, 16'($urandom), next_arrival(), 1'b0, none_r);
					counted++;
				end
			end
		end

		// drain and settle
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_outcomes.size() == 0)
			$display("[bounded_frame_fifo_with_stats] OK");
		else
			$display("[bounded_frame_fifo_with_stats] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/bffs_pkg.sv
design/bffs_ctrl.sv
design/bffs_dpath.sv
design/bounded_frame_fifo_with_stats.sv
tb/sv/tb_top.sv
